### sv/sfq_pkg.sv
// sfq_pkg: shared types and codes for the searchable fifo queue
// item structs, request and status codes, default sizes; no dependencies

package sfq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned POS_W          = 5;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_SRCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } sfq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } sfq_out_t;

  // search token control that walks down the cell chain
  typedef struct packed {
    logic             active;
    logic             done;
    logic             found;
    logic [POS_W-1:0] pos;
  } sfq_tok_t;

endpackage

### sv/sfq_cell.sv
// sfq_cell: one queue slot plus one stage of the search token path
// depends on sfq_pkg; instantiated in a row by searchable_fifo_queue

module sfq_cell
  import sfq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter logic [POS_W-1:0] CELL_POS = POS_W'(1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  enq,
  input  logic                  deq,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  prev_valid,
  input  logic                  next_valid,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  sfq_tok_t              tok_in,
  input  logic [DATA_WIDTH-1:0] key_in,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] data,
  output sfq_tok_t              tok_out,
  output logic [DATA_WIDTH-1:0] key_out
);

  logic                  valid_r, valid_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  sfq_tok_t              tok_r, tok_nxt;
  logic [DATA_WIDTH-1:0] key_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (deq) begin
      // everything moves one slot toward the head
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (enq && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      data_nxt  = wr_data;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active && !tok_in.done) begin
      if (!valid_r) begin
        // ran past the tail without a hit
        tok_nxt.done  = 1'b1;
        tok_nxt.found = 1'b0;
      end else if (data_r == key_in) begin
        tok_nxt.done  = 1'b1;
        tok_nxt.found = 1'b1;
        tok_nxt.pos   = CELL_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    key_r  <= key_in;
  end

  assign valid   = valid_r;
  assign data    = data_r;
  assign tok_out = tok_r;
  assign key_out = key_r;

endmodule

### sv/searchable_fifo_queue.sv
// searchable_fifo_queue: bounded fifo of values with a search request
// depends on sfq_pkg and sfq_cell
//
//   port group   dir  carries
//   in_*         in   request item: op, value
//   out_*        out  result item: status, position
//
// enqueue, dequeue and every refused or empty request: result the cycle after accept
// search on a non-empty queue: a token walks the cell row one cell per cycle,
//   result lands in the output register once the token has left the last cell
// one request in flight; in_stall is high during a search and while a result waits
// reset empties the queue; stored values need no clearing

module searchable_fifo_queue
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sfq_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output sfq_out_t out_item
);

  logic [DEPTH-1:0]      valid_vec;
  logic [DATA_WIDTH-1:0] data_vec [DEPTH];
  sfq_tok_t              tok_vec  [DEPTH];
  logic [DATA_WIDTH-1:0] key_vec  [DEPTH];
  logic [DEPTH-1:0]      tok_act;

  sfq_tok_t              tok_head;
  logic [DATA_WIDTH-1:0] wr_data;

  logic     busy_r, busy_nxt;
  logic     out_valid_r, out_valid_nxt;
  sfq_out_t out_item_r, out_item_nxt;

  logic accept, full, empty;
  logic enq_do, deq_do, srch_do;
  sfq_tok_t tail_tok;

  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = valid_vec[DEPTH-1];
  assign empty    = !valid_vec[0];
  assign enq_do   = accept && (in_item.op == OP_ENQ) && !full;
  assign deq_do   = accept && (in_item.op == OP_DEQ) && !empty;
  assign srch_do  = accept && (in_item.op == OP_SRCH) && !empty;
  assign wr_data  = DATA_WIDTH'(in_item.value);
  assign tail_tok = tok_vec[DEPTH-1];

  always_comb begin
    tok_head        = '0;
    tok_head.active = srch_do;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_v;
    logic                  next_v;
    logic [DATA_WIDTH-1:0] next_d;
    sfq_tok_t              t_in;
    logic [DATA_WIDTH-1:0] k_in;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
      assign t_in   = tok_head;
      assign k_in   = wr_data;
    end else begin : g_mid
      assign prev_v = valid_vec[i-1];
      assign t_in   = tok_vec[i-1];
      assign k_in   = key_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_inner
      assign next_v = valid_vec[i+1];
      assign next_d = data_vec[i+1];
    end

    sfq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_POS   (POS_W'(i + 1))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .enq        (enq_do),
      .deq        (deq_do),
      .wr_data    (wr_data),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_data  (next_d),
      .tok_in     (t_in),
      .key_in     (k_in),
      .valid      (valid_vec[i]),
      .data       (data_vec[i]),
      .tok_out    (tok_vec[i]),
      .key_out    (key_vec[i])
    );

    assign tok_act[i] = tok_vec[i].active;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    busy_nxt      = busy_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (tail_tok.active) begin
      busy_nxt              = 1'b0;
      out_valid_nxt         = 1'b1;
      out_item_nxt.status   = tail_tok.found ? ST_OK : ST_NOTFOUND;
      out_item_nxt.position = tail_tok.found ? tail_tok.pos : '0;
    end else if (srch_do) begin
      busy_nxt = 1'b1;
    end else if (accept) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.position = '0;
      unique case (in_item.op)
        OP_ENQ:  out_item_nxt.status = full ? ST_FULL : ST_OK;
        OP_DEQ:  out_item_nxt.status = empty ? ST_EMPTY : ST_OK;
        OP_SRCH: out_item_nxt.status = ST_EMPTY;
        default: out_item_nxt.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // live entries always sit packed at the head end of the row
  a_packed : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("queue entries not contiguous from head");

  // only one search token can be in the row
  a_one_tok : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_act))
    else $error("more than one search token in flight");

  // a token in the row means the input side is held off
  a_tok_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (tok_act != '0) |-> busy_r)
    else $error("search token without busy");

  // the queue does not move while a search walks it
  a_frozen : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && $past(busy_r) |-> $stable(valid_vec))
    else $error("queue changed during search");

endmodule
